// ===== rtl/arpc_pkg.sv =====
// shared constants, codes and beat structures for the arp cache
`default_nettype none
package arpc_pkg;

  // cache geometry
  localparam int CAPACITY = 8;
  localparam int IDX_W    = $clog2(CAPACITY);

  // field widths
  localparam int CMD_W = 2;
  localparam int IP_W  = 32;
  localparam int MAC_W = 48;

  // command codes
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LEARN  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PACKET = 2'd2;

  // register selects (paddr bit 3)
  localparam logic REG_OWN_IP  = 1'b0;
  localparam logic REG_OWN_MAC = 1'b1;

  // one input beat
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
    logic [IP_W-1:0]  tgt;
  } req_t;

  // one result beat
  typedef struct packed {
    logic             hit;
    logic [MAC_W-1:0] mac_out;
    logic             spoof;
    logic             reply;
    logic             evicted;
    logic [IP_W-1:0]  evicted_ip;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/arpc_cfg.sv =====
// apb register file holding the station's own ip and mac
`default_nettype none
module arpc_cfg
  import arpc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [3:0]       paddr,
  input  wire logic [63:0]      pwdata,
  output logic      [63:0]      prdata,
  output logic                  pready,
  output logic      [IP_W-1:0]  own_ip,
  output logic      [MAC_W-1:0] own_mac
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip  <= '0;
      own_mac <= '0;
    end else if (wr_en) begin
      case (paddr[3])
        REG_OWN_IP:  own_ip  <= pwdata[IP_W-1:0];
        REG_OWN_MAC: own_mac <= pwdata[MAC_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (paddr[3])
      REG_OWN_IP:  prdata = {{(64-IP_W){1'b0}}, own_ip};
      REG_OWN_MAC: prdata = {{(64-MAC_W){1'b0}}, own_mac};
      default:     prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/arpc_cam.sv =====
// register cam with lru ranks: match, decide and update in one pass
`default_nettype none
module arpc_cam
  import arpc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fire,
  input  wire req_t             req,
  input  wire logic [IP_W-1:0]  own_ip,
  input  wire logic [MAC_W-1:0] own_mac,
  output res_t                  res
);

  logic             entry_valid [CAPACITY];
  logic [IP_W-1:0]  entry_ip    [CAPACITY];
  logic [MAC_W-1:0] entry_mac   [CAPACITY];
  logic [IDX_W-1:0] age_rank    [CAPACITY];

  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] free_oh;
  logic [CAPACITY-1:0] victim_oh;
  logic                found;
  logic                full;
  logic [MAC_W-1:0]    found_mac;
  logic [IDX_W-1:0]    found_rank;
  logic [IP_W-1:0]     victim_ip;
  logic [MAC_W-1:0]    cached;
  logic                is_lookup;
  logic                is_learn;
  logic                is_pkt;
  logic                spoof;
  logic                for_us;
  logic                do_learn;
  logic                do_touch;
  logic                do_insert;

  // parallel compares; ips are unique among valid entries and valid
  // entries form a prefix, so every one-hot below has at most one bit set
  always_comb begin
    found_mac  = '0;
    found_rank = '0;
    victim_ip  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match[i]     = entry_valid[i] && (entry_ip[i] == req.ip);
      free_oh[i]   = !entry_valid[i] && ((i == 0) || entry_valid[(i == 0) ? 0 : i - 1]);
      victim_oh[i] = (age_rank[i] == IDX_W'(CAPACITY - 1));
      found_mac    = found_mac  | (match[i] ? entry_mac[i] : '0);
      found_rank   = found_rank | (match[i] ? age_rank[i] : '0);
      victim_ip    = victim_ip  | (victim_oh[i] ? entry_ip[i] : '0);
    end
    found = |match;
    full  = ~|free_oh;
  end

  // command decisions
  always_comb begin
    is_lookup = (req.cmd == CMD_LOOKUP);
    is_learn  = (req.cmd == CMD_LEARN);
    is_pkt    = (req.cmd == CMD_PACKET);
    cached    = found ? found_mac : '0;
    spoof     = is_pkt && (cached != '0) && (cached != req.mac);
    for_us    = is_pkt && !spoof && (req.tgt == own_ip);
    do_learn  = is_learn || for_us;
    do_touch  = found && (is_lookup || is_learn || is_pkt);
    do_insert = do_learn && !found;

    res.hit        = (is_lookup || is_pkt) && (cached != '0);
    res.mac_out    = (is_lookup && found) ? found_mac : (for_us ? own_mac : '0);
    res.spoof      = spoof;
    res.reply      = for_us;
    res.evicted    = do_insert && full;
    res.evicted_ip = (do_insert && full) ? victim_ip : '0;
  end

  // valid bits and ranks
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CAPACITY; i++) begin
        entry_valid[i] <= 1'b0;
        age_rank[i]    <= '0;
      end
    end else if (fire) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (do_touch) begin
          if (match[i])
            age_rank[i] <= '0;
          else if (entry_valid[i] && (age_rank[i] < found_rank))
            age_rank[i] <= age_rank[i] + IDX_W'(1);
        end else if (do_insert && !full) begin
          if (free_oh[i]) begin
            entry_valid[i] <= 1'b1;
            age_rank[i]    <= '0;
          end else if (entry_valid[i]) begin
            age_rank[i] <= age_rank[i] + IDX_W'(1);
          end
        end else if (do_insert) begin
          // table full: oldest entry becomes the newest, the rest age
          if (victim_oh[i])
            age_rank[i] <= '0;
          else
            age_rank[i] <= age_rank[i] + IDX_W'(1);
        end
      end
    end
  end

  // address payload, no reset
  always_ff @(posedge clk) begin
    if (fire) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (do_touch && do_learn && match[i]) begin
          entry_mac[i] <= req.mac;
        end else if (do_insert && (full ? victim_oh[i] : free_oh[i])) begin
          entry_ip[i]  <= req.ip;
          entry_mac[i] <= req.mac;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/arp_cache_lru_spoof_check.sv =====
// Top level of the ARP cache with LRU replacement and sender spoof check.
//
// Input beats arrive on the s_ stream: tuser carries the command (lookup,
// learn, received ARP packet), tdata the sender ip/mac and target ip.
// Every input beat yields exactly one result beat on the m_ stream.
// The station's own ip and mac sit in an APB register file (own_ip at 0x0,
// own_mac at 0x8); users must write them only while the block is idle (not enforced).
//
// An accepted beat is held in the input register, then the cam pass loads its
// result into the result register, which drives m_tvalid; a stalled receiver
// can keep the beat waiting in the input register.
// Throughput: one beat per cycle while the receiver does not stall; the cam
// lookup, decision and rank update of a beat are all done combinationally
// between the two registers, so the next beat already sees the updated table.
// When the receiver stalls the result register holds its beat, the input
// register takes one more beat, and s_tready then drops until m_tready
// returns.
// Reset empties the cache at once (valid bits clear), zeroes the ranks and
// the valid bits of both registers; no clearing pass is needed.
`default_nettype none
module arp_cache_lru_spoof_check
  import arpc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  // slave stream
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [111:0] s_tdata,  // addr_ip[31:0], addr_mac[79:32], target_ip[111:80]
  input  wire logic [1:0]   s_tuser,  // cmd[1:0]
  // master stream
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [87:0]       m_tdata,  // hit[0], mac_out[48:1], spoof[49], reply[50],
                                      // evicted[51], evicted_ip[83:52], zero[87:84]
  // configuration
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [63:0]  pwdata,
  output logic      [63:0]  prdata,
  output logic              pready
);

  logic             in_valid;
  req_t             in_req;
  logic             out_valid;
  res_t             out_res;
  res_t             cam_res;
  logic             advance;
  logic             fire;
  logic [IP_W-1:0]  own_ip;
  logic [MAC_W-1:0] own_mac;

  arpc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .own_ip  (own_ip),
    .own_mac (own_mac)
  );

  arpc_cam u_cam (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .req     (in_req),
    .own_ip  (own_ip),
    .own_mac (own_mac),
    .res     (cam_res)
  );

  // handshake
  assign advance  = !out_valid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_req.cmd <= s_tuser;
      in_req.ip  <= s_tdata[31:0];
      in_req.mac <= s_tdata[79:32];
      in_req.tgt <= s_tdata[111:80];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= cam_res;
    end
  end

  // result beat packing
  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0, out_res.evicted_ip, out_res.evicted, out_res.reply,
                     out_res.spoof, out_res.mac_out, out_res.hit};

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// stream and apb testbench for the arp cache with lru replacement and spoof check
`timescale 1ns / 1ps

module tb_top;
  import arpc_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [3:0] ADDR_OWN_IP  = {REG_OWN_IP, 3'b000};
  localparam logic [3:0] ADDR_OWN_MAC = {REG_OWN_MAC, 3'b000};
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int POOL_N      = 12;

  // lru cache mirror with its queue of predicted answers
  class arp_scoreboard;
    logic [IP_W-1:0]  station_ip;
    logic [MAC_W-1:0] station_mac;
    bit               slot_used[CAPACITY];
    logic [IP_W-1:0]  slot_ip[CAPACITY];
    logic [MAC_W-1:0] slot_mac[CAPACITY];
    int               slot_age[CAPACITY];
    res_t             answers[$];
    int               errors;

    function new();
      station_ip  = '0;
      station_mac = '0;
      errors      = 0;
      for (int i = 0; i < CAPACITY; i++) begin
        slot_used[i] = 1'b0;
        slot_ip[i]   = '0;
        slot_mac[i]  = '0;
        slot_age[i]  = 0;
      end
    endfunction

    function int pending();
      return answers.size();
    endfunction

    function int find_slot(logic [IP_W-1:0] ip);
      for (int i = 0; i < CAPACITY; i++)
        if (slot_used[i] && slot_ip[i] == ip) return i;
      return -1;
    endfunction

    // younger valid entries age by one, k becomes newest
    function void make_newest(int k);
      int r;
      r = slot_age[k];
      for (int i = 0; i < CAPACITY; i++)
        if (i != k && slot_used[i] && slot_age[i] < r) slot_age[i]++;
      slot_age[k] = 0;
    endfunction

    // update in place, fill the lowest free slot, or replace the oldest
    function void store_pair(logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac,
                             output logic ev, output logic [IP_W-1:0] ev_ip);
      int k;
      ev    = 1'b0;
      ev_ip = '0;
      k     = find_slot(ip);
      if (k >= 0) begin
        make_newest(k);
        slot_mac[k] = mac;
        return;
      end
      for (int i = 0; i < CAPACITY; i++)
        if (!slot_used[i] && k < 0) k = i;
      if (k >= 0) begin
        for (int i = 0; i < CAPACITY; i++)
          if (slot_used[i]) slot_age[i]++;
        slot_used[k] = 1'b1;
        slot_age[k]  = 0;
      end else begin
        k = 0;
        for (int i = 1; i < CAPACITY; i++)
          if (slot_age[i] > slot_age[k]) k = i;
        ev    = 1'b1;
        ev_ip = slot_ip[k];
        make_newest(k);
      end
      slot_ip[k]  = ip;
      slot_mac[k] = mac;
    endfunction

    // work out the answer to one accepted request beat
    function void note_request(req_t r);
      res_t             a;
      int               k;
      logic [MAC_W-1:0] cached;
      a = '0;
      case (r.cmd)
        CMD_LOOKUP: begin
          k = find_slot(r.ip);
          if (k >= 0) begin
            make_newest(k);
            a.mac_out = slot_mac[k];
            a.hit     = (slot_mac[k] != '0);
          end
        end
        CMD_LEARN: begin
          store_pair(r.ip, r.mac, a.evicted, a.evicted_ip);
        end
        CMD_PACKET: begin
          cached = '0;
          k = find_slot(r.ip);
          if (k >= 0) begin
            make_newest(k);
            cached = slot_mac[k];
          end
          a.hit = (cached != '0);
          if (cached != '0 && cached != r.mac) begin
            a.spoof = 1'b1;
          end else if (r.tgt == station_ip) begin
            store_pair(r.ip, r.mac, a.evicted, a.evicted_ip);
            a.reply   = 1'b1;
            a.mac_out = station_mac;
          end
        end
        default: begin
        end
      endcase
      answers.push_back(a);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h, expected %0h", what, got, want);
      errors++;
    endtask

    task check_answer(res_t got);
      res_t want;
      if (answers.size() == 0) begin
        report("result beat with nothing outstanding", got.mac_out, '0);
        return;
      end
      want = answers.pop_front();
      if (got.hit !== want.hit) report("hit", got.hit, want.hit);
      if (got.mac_out !== want.mac_out) report("mac_out", got.mac_out, want.mac_out);
      if (got.spoof !== want.spoof) report("spoof", got.spoof, want.spoof);
      if (got.reply !== want.reply) report("reply", got.reply, want.reply);
      if (got.evicted !== want.evicted) report("evicted", got.evicted, want.evicted);
      if (got.evicted_ip !== want.evicted_ip)
        report("evicted_ip", got.evicted_ip, want.evicted_ip);
    endtask
  endclass

  logic         clk;
  logic         rst      = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [111:0] s_tdata  = '0;  // addr_ip[31:0], addr_mac[79:32], target_ip[111:80]
  logic [1:0]   s_tuser  = '0;  // cmd[1:0]
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [87:0]  m_tdata;        // hit[0], mac_out[48:1], spoof[49], reply[50],
                                // evicted[51], evicted_ip[83:52], zero[87:84]
  logic         psel     = 1'b0;
  logic         penable  = 1'b0;
  logic         pwrite   = 1'b0;
  logic [3:0]   paddr    = '0;
  logic [63:0]  pwdata   = '0;
  logic [63:0]  prdata;
  logic         pready;

  arp_scoreboard sb;
  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_req  = 0;
  int hold_ack  = 0;
  int hold_left = 0;
  int quiet     = 0;

  arp_cache_lru_spoof_check dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_ack != hold_req) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // beat monitor and watchdog; results are checked before new requests are noted
  always @(posedge clk) begin : monitor
    req_t rq;
    res_t got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.hit        = m_tdata[0];
        got.mac_out    = m_tdata[48:1];
        got.spoof      = m_tdata[49];
        got.reply      = m_tdata[50];
        got.evicted    = m_tdata[51];
        got.evicted_ip = m_tdata[83:52];
        sb.check_answer(got);
        if (m_tdata[87:84] !== 4'd0) sb.report("tdata padding", m_tdata[87:84], '0);
      end
      if (s_tvalid && s_tready) begin
        rq.cmd = s_tuser;
        rq.ip  = s_tdata[31:0];
        rq.mac = s_tdata[79:32];
        rq.tgt = s_tdata[111:80];
        sb.note_request(rq);
      end
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= QUIET_LIMIT) begin
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  // offer one request beat, after a random gap, and hold it until taken
  task automatic send_beat(logic [CMD_W-1:0] cmd, logic [IP_W-1:0] ip,
                           logic [MAC_W-1:0] mac, logic [IP_W-1:0] tgt);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {tgt, mac, ip};
    do @(posedge clk); while (!s_tready);
  endtask

  // stop offering and wait for every outstanding answer
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic apb_write(logic [3:0] addr, logic [63:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // station address change, only with the block idle
  task automatic set_station(logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac);
    drain();
    apb_write(ADDR_OWN_IP, {32'd0, ip});
    apb_write(ADDR_OWN_MAC, {16'd0, mac});
    sb.station_ip  = ip;
    sb.station_mac = mac;
  endtask

  // mostly a small pool of stations so hits, evictions and spoofs are common
  task automatic run_random(int count);
    logic [IP_W-1:0]  pool_ip[POOL_N];
    logic [MAC_W-1:0] pool_mac[POOL_N];
    logic [CMD_W-1:0] cmd;
    logic [IP_W-1:0]  ip;
    logic [IP_W-1:0]  tgt;
    logic [MAC_W-1:0] mac;
    int               sel;
    int               pick;
    for (int i = 0; i < POOL_N; i++) begin
      pool_ip[i]  = $urandom;
      pool_mac[i] = {16'($urandom), 32'($urandom)};
    end
    pool_ip[0] = '0;
    pool_ip[1] = '1;
    for (int n = 0; n < count; n++) begin
      sel  = $urandom_range(99);
      cmd  = (sel < 30) ? CMD_LOOKUP : (sel < 60) ? CMD_LEARN :
             (sel < 97) ? CMD_PACKET : CMD_UNUSED;
      pick = $urandom_range(POOL_N - 1);
      ip   = ($urandom_range(99) < 85) ? pool_ip[pick] : $urandom;
      sel  = $urandom_range(99);
      mac  = (sel < 60) ? pool_mac[pick] :
             (sel < 80) ? {16'($urandom), 32'($urandom)} :
             (sel < 90) ? '0 : '1;
      sel  = $urandom_range(99);
      tgt  = (sel < 60) ? sb.station_ip :
             (sel < 80) ? pool_ip[$urandom_range(POOL_N - 1)] : $urandom;
      send_beat(cmd, ip, mac, tgt);
    end
  endtask

  initial begin : stimulus
    int idle_tab[5];
    int stall_tab[5];
    idle_tab  = '{0, 83, 0, 7, 0};
    stall_tab = '{0, 0, 83, 7, 0};
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed pass with light idling on both sides
    idle_pct = 7;
    stall_pct <= 7;
    set_station(32'h0A00_0001, 48'h0200_5E00_0001);
    send_beat(CMD_LOOKUP, '0, '1, '1);                  // empty cache miss
    send_beat(CMD_LEARN, '0, '1, '0);
    send_beat(CMD_LOOKUP, '0, '0, '0);                  // hit
    send_beat(CMD_LEARN, '1, '0, '1);                   // zero mac stored
    send_beat(CMD_LOOKUP, '1, '1, '0);                  // zero mac counts as absent
    send_beat(CMD_PACKET, '1, 48'h1234_5678_9ABC, '1);  // zero-mac sender, not for us
    for (int i = 1; i <= 7; i++)                        // fill up, last one evicts
      send_beat(CMD_LEARN, 32'h0A00_0010 + i, 48'h0000_0000_00A0 + i, '0);
    send_beat(CMD_LEARN, 32'h0A00_0013, 48'h0000_0000_BEEF, '0);  // update in place
    send_beat(CMD_PACKET, 32'h0A00_0014, 48'h0000_0000_DEAD, 32'h0A00_0001);  // spoofed
    send_beat(CMD_PACKET, 32'h0A00_0015, 48'h0000_0000_00A5, 32'h0A00_0001);  // known, for us
    send_beat(CMD_PACKET, 32'h0B00_0001, 48'h0A0B_0C0D_0E0F, 32'h0A00_0001);  // new, for us
    send_beat(CMD_PACKET, 32'h0B00_0002, 48'h0102_0304_0506, '0);  // unknown, not for us
    send_beat(CMD_UNUSED, '1, '1, '1);
    send_beat(CMD_LOOKUP, 32'h0B00_0003, '0, '0);       // miss

    // random phases, each setting its station address and idling mix
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: set_station('0, '0);
        1: set_station('1, '1);
        default: set_station($urandom, {16'($urandom), 32'($urandom)});
      endcase
      idle_pct = idle_tab[p];
      stall_pct <= stall_tab[p];
      if (p == 0) hold_req <= hold_req + 1;
      run_random(400);
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== arp_cache_lru_spoof_check.f =====
rtl/arpc_pkg.sv
rtl/arpc_cfg.sv
rtl/arpc_cam.sv
rtl/arp_cache_lru_spoof_check.sv
tb/tb_top.sv
